FILE: hw/rtl/descending_stable_record_sorter_defines.svh
// assertion macros for the descending stable record sorter
// used by the checker, no other dependencies
`ifndef DESCENDING_STABLE_RECORD_SORTER_DEFINES_SVH
`define DESCENDING_STABLE_RECORD_SORTER_DEFINES_SVH

// implication checked in the same cycle
`define DSRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define DSRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dsrs_pkg.sv
// shared types and constants for the descending stable record sorter
// no dependencies
package dsrs_pkg;

  localparam int unsigned ScoreW = 16;
  localparam int unsigned TagW = 16;
  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned ScoreBitsDef = 16;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   tag;
    logic              last;
  } in_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   tag;
    logic              last;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/dsrs_cell.sv
// one cell of the insertion chain: holds a record, compares it with the incoming one
// depends on dsrs_pkg
module dsrs_cell #(
  parameter int unsigned KeyBits = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dsrs_pkg::cell_ctrl_t           ctrl_i,
  input  logic [KeyBits-1:0]             new_key_i,
  input  logic [dsrs_pkg::TagW-1:0]      new_tag_i,
  input  logic                           prev_keep_i,
  input  logic                           prev_valid_i,
  input  logic [KeyBits-1:0]             prev_key_i,
  input  logic [dsrs_pkg::TagW-1:0]      prev_tag_i,
  input  logic                           next_valid_i,
  input  logic [KeyBits-1:0]             next_key_i,
  input  logic [dsrs_pkg::TagW-1:0]      next_tag_i,
  output logic                           keep_o,
  output logic                           valid_o,
  output logic [KeyBits-1:0]             key_o,
  output logic [dsrs_pkg::TagW-1:0]      tag_o
);

  logic                      valid_q, valid_d;
  logic [KeyBits-1:0]        key_q, key_d;
  logic [dsrs_pkg::TagW-1:0] tag_q, tag_d;

  // equal scores stay ahead of the newcomer
  assign keep_o = valid_q && (key_q >= new_key_i);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tag_d   = tag_q;
    if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      key_d   = next_key_i;
      tag_d   = next_tag_i;
    end else if (ctrl_i.insert && !keep_o) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        key_d   = new_key_i;
        tag_d   = new_tag_i;
      end else begin
        valid_d = prev_valid_i;
        key_d   = prev_key_i;
        tag_d   = prev_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign tag_o   = tag_q;

endmodule

FILE: hw/rtl/descending_stable_record_sorter.sv
// Stable descending record sorter. Records (score, tag) enter one per cycle while input ready
// is high into a chain of MAX_ENTRIES insertion cells that keeps them ordered by score, highest
// first, equal scores in arrival order; only the low SCORE_BITS bits of the score count. The
// transaction marked last closes the batch: the chain then shifts its records out one per
// cycle, unless the output stalls, through an output register; input ready stays low until
// the final record of the batch has been loaded. Records beyond MAX_ENTRIES are dropped and
// every result of that batch carries the overflow flag.
// Depends on dsrs_pkg and dsrs_cell.
module descending_stable_record_sorter #(
  parameter int unsigned MAX_ENTRIES = dsrs_pkg::MaxEntriesDef,
  parameter int unsigned SCORE_BITS  = dsrs_pkg::ScoreBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dsrs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dsrs_pkg::out_t out_data_o
);

  localparam int unsigned KeyBits =
    (SCORE_BITS < dsrs_pkg::ScoreW) ? SCORE_BITS : dsrs_pkg::ScoreW;

  logic                      draining_q, draining_d;
  logic                      ovf_q, ovf_d;
  logic                      out_valid_q, out_valid_d;
  dsrs_pkg::out_t            out_q, out_d;

  logic                      in_acc, full, load_out;
  dsrs_pkg::cell_ctrl_t      ctrl;
  logic [KeyBits-1:0]        new_key;

  logic [MAX_ENTRIES-1:0]    keep, valid;
  logic [KeyBits-1:0]        key [MAX_ENTRIES];
  logic [dsrs_pkg::TagW-1:0] tag [MAX_ENTRIES];

  assign new_key     = in_data_i.score[KeyBits-1:0];
  assign in_ready_o  = !draining_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign full        = valid[MAX_ENTRIES-1];
  assign load_out    = draining_q && valid[0] && (!out_valid_q || out_ready_i);
  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = load_out;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                      p_keep, p_valid, n_valid;
    logic [KeyBits-1:0]        p_key, n_key;
    logic [dsrs_pkg::TagW-1:0] p_tag, n_tag;

    if (i == 0) begin : g_head
      assign p_keep  = 1'b1;
      assign p_valid = 1'b0;
      assign p_key   = '0;
      assign p_tag   = '0;
    end else begin : g_body
      assign p_keep  = keep[i-1];
      assign p_valid = valid[i-1];
      assign p_key   = key[i-1];
      assign p_tag   = tag[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_key   = '0;
      assign n_tag   = '0;
    end else begin : g_inner
      assign n_valid = valid[i+1];
      assign n_key   = key[i+1];
      assign n_tag   = tag[i+1];
    end

    dsrs_cell #(
      .KeyBits(KeyBits)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_key_i   (new_key),
      .new_tag_i   (in_data_i.tag),
      .prev_keep_i (p_keep),
      .prev_valid_i(p_valid),
      .prev_key_i  (p_key),
      .prev_tag_i  (p_tag),
      .next_valid_i(n_valid),
      .next_key_i  (n_key),
      .next_tag_i  (n_tag),
      .keep_o      (keep[i]),
      .valid_o     (valid[i]),
      .key_o       (key[i]),
      .tag_o       (tag[i])
    );
  end

  always_comb begin
    draining_d  = draining_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      if (full) begin
        ovf_d = 1'b1;
      end
      if (in_data_i.last) begin
        draining_d = 1'b1;
      end
    end
    if (load_out) begin
      out_valid_d    = 1'b1;
      out_d.score    = dsrs_pkg::ScoreW'(key[0]);
      out_d.tag      = tag[0];
      out_d.last     = !valid[1];
      out_d.overflow = ovf_q;
      if (!valid[1]) begin
        draining_d = 1'b0;
        ovf_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q  <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      draining_q  <= draining_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/dsrs_checker.sv
// port-level checks for the descending stable record sorter, bound to the top level
// depends on dsrs_pkg and descending_stable_record_sorter_defines.svh
`include "descending_stable_record_sorter_defines.svh"

module dsrs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input dsrs_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input dsrs_pkg::out_t out_data_o
);

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  `DSRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")
  `DSRS_ASSERT_NEXT(a_last_closes, clk_i, rst_ni, in_acc && in_data_i.last, !in_ready_o, "input still open after last transaction")
  `DSRS_ASSERT_SAME(a_busy_mid_batch, clk_i, rst_ni, out_valid_o && !out_data_o.last, !in_ready_o, "input open during batch output")
  `DSRS_ASSERT_NEXT(a_batch_flow, clk_i, rst_ni, out_acc && !out_data_o.last, out_valid_o && (out_data_o.overflow == $past(out_data_o.overflow)) && (out_data_o.score <= $past(out_data_o.score)), "batch output broken")

endmodule

bind descending_stable_record_sorter dsrs_checker u_dsrs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

FILE: tb/dsrs_sort_checker.sv
`timescale 1ns / 100ps
// checker for the descending stable record sorter: watches both channels, keeps its own
// ordered copy of each batch and compares every emitted record field by field
// depends on dsrs_pkg
module dsrs_sort_checker #(
  parameter int unsigned MAX_ENTRIES = dsrs_pkg::MaxEntriesDef,
  parameter int unsigned SCORE_BITS  = dsrs_pkg::ScoreBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  dsrs_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  dsrs_pkg::out_t out_data_i,
  output int             pending_o,
  output int             fail_count_o
);

  localparam int unsigned ScoreW = dsrs_pkg::ScoreW;
  localparam int unsigned TagW   = dsrs_pkg::TagW;

  localparam logic [ScoreW-1:0] ScoreMask = (SCORE_BITS >= ScoreW) ? {ScoreW{1'b1}} :
                                            ScoreW'((64'd1 << SCORE_BITS) - 64'd1);

  logic [ScoreW-1:0] batch_score [MAX_ENTRIES];
  logic [TagW-1:0]   batch_tag   [MAX_ENTRIES];
  int                batch_fill = 0;
  logic              batch_dropped = 1'b0;
  dsrs_pkg::out_t    sorted_records_q [$];
  int                mismatches = 0;

  // place the record after every stored record with a score >= its own
  task automatic rank_insert(input dsrs_pkg::in_t rec);
    logic [ScoreW-1:0] key;
    dsrs_pkg::out_t    rec_out;
    int pos;
    int k;
    key = rec.score & ScoreMask;
    if (batch_fill < MAX_ENTRIES) begin
      pos = batch_fill;
      while (pos > 0 && batch_score[pos-1] < key) begin
        batch_score[pos] = batch_score[pos-1];
        batch_tag[pos] = batch_tag[pos-1];
        pos--;
      end
      batch_score[pos] = key;
      batch_tag[pos] = rec.tag;
      batch_fill++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (rec.last) begin
      for (k = 0; k < batch_fill; k++) begin
        rec_out.score    = batch_score[k];
        rec_out.tag      = batch_tag[k];
        rec_out.last     = (k == batch_fill - 1);
        rec_out.overflow = batch_dropped;
        sorted_records_q = {sorted_records_q, rec_out};
      end
      batch_fill = 0;
      batch_dropped = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    dsrs_pkg::out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        rank_insert(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (sorted_records_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected record, expected none, got score %h tag %h last %b ovf %b",
                   $time, out_data_i.score, out_data_i.tag, out_data_i.last,
                   out_data_i.overflow);
        end else begin
          want = sorted_records_q.pop_front();
          check_field("score", 32'(want.score), 32'(out_data_i.score));
          check_field("tag", 32'(want.tag), 32'(out_data_i.tag));
          check_field("last", 32'(want.last), 32'(out_data_i.last));
          check_field("overflow", 32'(want.overflow), 32'(out_data_i.overflow));
        end
      end
    end
    pending_o <= sorted_records_q.size();
    fail_count_o <= mismatches;
  end

endmodule

FILE: tb/tb_descending_stable_record_sorter.sv
`timescale 1ns / 100ps
// testbench top for the descending stable record sorter: directed and random batches,
// including a full store and an overflowing batch, under varying idle and stall rates
// depends on dsrs_pkg, descending_stable_record_sorter and dsrs_sort_checker
module tb_descending_stable_record_sorter;

  localparam int unsigned ScoreW = dsrs_pkg::ScoreW;
  localparam int unsigned TagW   = dsrs_pkg::TagW;
  localparam int NumDirected = 20;
  localparam logic [ScoreW-1:0] DirScores [NumDirected] = '{
    16'hFFFF, 16'h0000,
    16'h0005, 16'h0005, 16'hFFFF, 16'h0005, 16'h0000, 16'hFFFF, 16'h0000,
    16'h0001, 16'h0002, 16'h0003, 16'h0004,
    16'hFFFF, 16'h8000, 16'h0001,
    16'h1234, 16'h1234, 16'h1234, 16'h1234
  };
  localparam logic [0:NumDirected-1] DirLast = 20'b1_1_0000001_0001_001_0001;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  dsrs_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  dsrs_pkg::out_t out_data;
  int             pending;
  int             fail_count;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;

  descending_stable_record_sorter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  dsrs_sort_checker u_sort_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ties and extremes for half the picks, to exercise the stable ordering
  function automatic logic [ScoreW-1:0] pick_score();
    case ($urandom_range(0, 3))
      0: return ScoreW'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? {ScoreW{1'b1}} : {ScoreW{1'b0}};
      default: return ScoreW'($urandom);
    endcase
  endfunction

  task automatic send_record(input logic [ScoreW-1:0] score, input logic [TagW-1:0] tag,
                             input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= '{score: score, tag: tag, last: last};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_batch(input int count);
    for (int i = 0; i < count; i++) begin
      send_record(pick_score(), TagW'($urandom), i == count - 1);
    end
  endtask

  initial begin
    int budget;
    int size;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 62 : 0;
      recv_stall_pct = (phase == 0) ? 62 : (phase == 1) ? 30 : 0;
      if (phase == 0) begin
        for (int i = 0; i < NumDirected; i++) begin
          send_record(DirScores[i], TagW'(i), DirLast[i]);
        end
        send_batch(int'(dsrs_pkg::MaxEntriesDef));
      end
      if (phase == 1) begin
        send_batch(int'(dsrs_pkg::MaxEntriesDef) + int'($urandom_range(1, 3)));
      end
      budget = 40;
      while (budget > 0) begin
        size = $urandom_range(1, 8);
        send_batch(size);
        budget -= size;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: descending_stable_record_sorter.f
+incdir+hw/rtl
hw/rtl/dsrs_pkg.sv
hw/rtl/dsrs_cell.sv
hw/rtl/descending_stable_record_sorter.sv
hw/rtl/dsrs_checker.sv
tb/dsrs_sort_checker.sv
tb/tb_descending_stable_record_sorter.sv
